### design/sms_pkg.sv
// Shared types and constants for the stepper move sequencer.
// Used by sms_core and stepper_move_sequencer_top; no dependencies.
package sms_pkg;

   localparam int POSITION_BITS_DEF = 32;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_STEP_MODE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_PATTERN_TABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_PATTERN_TABLE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOME_SWITCH_ENABLE = 2'd3;

   localparam logic [15:0] FULL_TABLE_RESET = 16'h936C;
   localparam logic [31:0] HALF_TABLE_RESET = 32'h9132_64C8;

   localparam logic [2:0] RING_FULL = 3'd3;
   localparam logic [2:0] RING_HALF = 3'd7;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_LOAD = 2'd1,
      KIND_OFF  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      EV_IDLE      = 3'd0,
      EV_STEPPED   = 3'd1,
      EV_ENDED     = 3'd2,
      EV_SET_HOME  = 3'd3,
      EV_FIND_HOME = 3'd4
   } event_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] position_value;
      logic signed [31:0] target_value;
      logic               direction;
      logic               home_switch_closed;
   } req_type;

   typedef struct packed {
      logic [3:0]         coil_pattern;
      logic signed [31:0] position_out;
      event_type          event_res;
      logic               moving;
   } rsp_type;

   typedef struct packed {
      logic        half_step_mode;
      logic [15:0] full_pattern_table;
      logic [31:0] half_pattern_table;
      logic        home_switch_enable;
   } cfg_type;

endpackage

### design/sms_core.sv
// Move state and per-item step logic of the stepper move sequencer.
// Depends on sms_pkg. Result is combinational from the held state and the item.
module sms_core
   import sms_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] target_ff, target_in;
   logic                     direction_ff, direction_in;
   logic [2:0]               phase_ff, phase_in;
   logic                     running_ff, running_in;
   logic [3:0]               coils_ff, coils_in;

   logic [2:0]               ring;
   logic [2:0]               phase_step;
   logic [POSITION_BITS-1:0] position_step;
   event_type                event_val;

   always_comb begin
      ring          = cfg.half_step_mode ? RING_HALF : RING_FULL;
      phase_step    = direction_ff ? ((phase_ff + 3'd1) & ring) : ((phase_ff - 3'd1) & ring);
      position_step = direction_ff ? (position_ff - POSITION_BITS'(1))
                                   : (position_ff + POSITION_BITS'(1));

      position_in  = position_ff;
      target_in    = target_ff;
      direction_in = direction_ff;
      phase_in     = phase_ff;
      running_in   = running_ff;
      coils_in     = coils_ff;
      event_val    = EV_IDLE;

      unique case (item.kind)
         KIND_TICK: begin
            if (running_ff) begin
               if (position_ff == target_ff) begin
                  running_in = 1'b0;
                  event_val  = EV_ENDED;
               end else begin
                  phase_in    = phase_step;
                  coils_in    = cfg.half_step_mode ?
                                cfg.half_pattern_table[{phase_step, 2'b00} +: 4] :
                                cfg.full_pattern_table[{phase_step[1:0], 2'b00} +: 4];
                  position_in = position_step;
                  event_val   = EV_STEPPED;
                  if (direction_ff && cfg.home_switch_enable) begin
                     priority if (item.home_switch_closed && !position_step[POSITION_BITS-1]) begin
                        running_in  = 1'b0;
                        position_in = '0;
                        target_in   = '0;
                        event_val   = EV_SET_HOME;
                     end else if (!item.home_switch_closed && position_step == '0) begin
                        running_in  = 1'b0;
                        position_in = '0;
                        target_in   = '0;
                        event_val   = EV_FIND_HOME;
                     end else begin
                     end
                  end
               end
            end
         end
         KIND_LOAD: begin
            position_in  = POSITION_BITS'(64'(item.position_value));
            target_in    = POSITION_BITS'(64'(item.target_value));
            direction_in = item.direction;
            running_in   = 1'b1;
         end
         KIND_OFF: begin
            coils_in = 4'd0;
         end
         default: begin
         end
      endcase

      result.coil_pattern = coils_in;
      result.position_out = 32'(64'($signed(position_in)));
      result.event_res    = event_val;
      result.moving       = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         target_ff    <= '0;
         direction_ff <= 1'b0;
         phase_ff     <= 3'd0;
         running_ff   <= 1'b0;
         coils_ff     <= 4'd0;
      end else if (fire) begin
         position_ff  <= position_in;
         target_ff    <= target_in;
         direction_ff <= direction_in;
         phase_ff     <= phase_in;
         running_ff   <= running_in;
         coils_ff     <= coils_in;
      end
   end

endmodule

### design/stepper_move_sequencer_top.sv
// Stepper move sequencer: request register, move core and result register.
// Depends on sms_pkg and sms_core.
//
// One result item for every request item. An item passes a request register,
// then the move core computes the next state and result combinationally and
// the result is registered in the result register, which sets rsp_valid; the
// item waits in the request register while a held result is stalled.
// One item per cycle is sustained while rsp_stall is low: the request register refills while a result
// waits on rsp_stall, and req_stall rises only when both stages hold items.
// Configuration writes take effect at once and are meant for idle periods.
module stepper_move_sequencer_top
   import sms_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   logic    s1_valid_ff;
   req_type s1_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type core_result;
   logic    s1_advance;
   logic    req_accept;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_step_mode     <= 1'b0;
         cfg_ff.full_pattern_table <= FULL_TABLE_RESET;
         cfg_ff.half_pattern_table <= HALF_TABLE_RESET;
         cfg_ff.home_switch_enable <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HALF_STEP_MODE:     cfg_ff.half_step_mode     <= csr_wdata[0];
            CSR_FULL_PATTERN_TABLE: cfg_ff.full_pattern_table <= csr_wdata[15:0];
            CSR_HALF_PATTERN_TABLE: cfg_ff.half_pattern_table <= csr_wdata;
            CSR_HOME_SWITCH_ENABLE: cfg_ff.home_switch_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept)
            s1_valid_ff <= 1'b1;
         else if (s1_advance)
            s1_valid_ff <= 1'b0;
         if (s1_advance)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept)
         s1_ff <= req_data;
      if (s1_advance)
         rsp_ff <= core_result;
   end

   sms_core #(
      .POSITION_BITS(POSITION_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_advance),
      .item   (s1_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // a held request must not be replaced
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("request register overwritten while held");

   // a stalled result must not be replaced
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result register overwritten while stalled");

   // every stop event ends the move
   a_stop_not_moving: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_res == EV_ENDED || rsp_ff.event_res == EV_SET_HOME
       || rsp_ff.event_res == EV_FIND_HOME)) |-> !rsp_ff.moving)
      else $error("stop event with move still running");

   // homing zeroes the position
   a_home_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_res == EV_SET_HOME || rsp_ff.event_res == EV_FIND_HOME))
      |-> (rsp_ff.position_out == '0))
      else $error("home event with nonzero position");

   // a step keeps the move running
   a_step_moving: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_res == EV_STEPPED) |-> rsp_ff.moving)
      else $error("stepped item reports move stopped");

endmodule

### tb/sms_move_checker.sv
// Checker for the stepper move sequencer: follows accepted items and register
// writes, predicts each result and compares it with the result channel.
// Depends on sms_pkg.
module sms_move_checker
   import sms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        outcomes_pending
);

   cfg_type     motor_cfg;
   logic [31:0] position;
   logic [31:0] target;
   logic        move_in;
   logic [2:0]  phase;
   logic        running;
   logic [3:0]  coils;
   rsp_type     queued_outcomes[$];
   int          fails = 0;

   function automatic rsp_type motor_step(input req_type r);
      rsp_type    o;
      event_type  ev;
      logic [2:0] ring;
      ev = EV_IDLE;
      case (r.kind)
         KIND_TICK: begin
            if (running) begin
               if (position == target) begin
                  running = 1'b0;
                  ev = EV_ENDED;
               end else begin
                  ring = motor_cfg.half_step_mode ? RING_HALF : RING_FULL;
                  phase = (move_in ? phase + 3'd1 : phase - 3'd1) & ring;
                  if (motor_cfg.half_step_mode)
                     coils = motor_cfg.half_pattern_table[phase*4 +: 4];
                  else
                     coils = motor_cfg.full_pattern_table[phase*4 +: 4];
                  position = move_in ? position - 32'd1 : position + 32'd1;
                  ev = EV_STEPPED;
                  if (move_in && motor_cfg.home_switch_enable) begin
                     if (r.home_switch_closed && !position[31]) begin
                        running = 1'b0;
                        position = '0;
                        target = '0;
                        ev = EV_SET_HOME;
                     end else if (!r.home_switch_closed && position == 32'd0) begin
                        running = 1'b0;
                        position = '0;
                        target = '0;
                        ev = EV_FIND_HOME;
                     end
                  end
               end
            end
         end
         KIND_LOAD: begin
            position = r.position_value;
            target   = r.target_value;
            move_in  = r.direction;
            running  = 1'b1;
         end
         KIND_OFF: coils = '0;
         default: ;
      endcase
      o.coil_pattern = coils;
      o.position_out = position;
      o.event_res    = ev;
      o.moving       = running;
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         motor_cfg.half_step_mode     = 1'b0;
         motor_cfg.full_pattern_table = FULL_TABLE_RESET;
         motor_cfg.half_pattern_table = HALF_TABLE_RESET;
         motor_cfg.home_switch_enable = 1'b1;
         position = '0;
         target   = '0;
         move_in  = 1'b0;
         phase    = '0;
         running  = 1'b0;
         coils    = '0;
         queued_outcomes.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_HALF_STEP_MODE:     motor_cfg.half_step_mode = csr_wdata[0];
               CSR_FULL_PATTERN_TABLE: motor_cfg.full_pattern_table = csr_wdata[15:0];
               CSR_HALF_PATTERN_TABLE: motor_cfg.half_pattern_table = csr_wdata;
               CSR_HOME_SWITCH_ENABLE: motor_cfg.home_switch_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (queued_outcomes.size() == 0) begin
               if (fails < 10)
                  $display("checker: unexpected result coils=%h pos=%h ev=%0d moving=%b",
                           rsp_data.coil_pattern, rsp_data.position_out,
                           rsp_data.event_res, rsp_data.moving);
               fails++;
            end else begin
               want = queued_outcomes.pop_front();
               if (want.coil_pattern !== rsp_data.coil_pattern ||
                   want.position_out !== rsp_data.position_out ||
                   want.event_res !== rsp_data.event_res ||
                   want.moving !== rsp_data.moving) begin
                  if (fails < 10) begin
                     $write("checker: mismatch expected coils=%h pos=%h ev=%0d moving=%b",
                            want.coil_pattern, want.position_out, want.event_res,
                            want.moving);
                     $display(" got coils=%h pos=%h ev=%0d moving=%b",
                              rsp_data.coil_pattern, rsp_data.position_out,
                              rsp_data.event_res, rsp_data.moving);
                  end
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall)
            queued_outcomes.push_back(motor_step(req_data));
      end
      outcomes_pending <= queued_outcomes.size();
      fail_count       <= fails;
   end

endmodule

### tb/tb_top.sv
// Testbench top for stepper_move_sequencer_top: clock, reset, register
// settings, directed and random move items, handshake idling and verdict.
// Depends on sms_pkg, stepper_move_sequencer_top and sms_move_checker.
module tb_top;
   import sms_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int fail_count;
   int outcomes_pending;
   int send_pct = 0;
   int rsp_idle_pct = 0;
   int items_sent = 0;
   int settings_used = 1;
   int quiet_cycles = 0;
   bit hold_toggle = 1'b0;

   always #10 clock = ~clock;

   stepper_move_sequencer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sms_move_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .outcomes_pending (outcomes_pending)
   );

   // result side: random stall, or a long hold-off when asked
   initial begin : rsp_side
      bit seen;
      seen = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen) begin
            seen = hold_toggle;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: watchdog expired, %0d results outstanding", outcomes_pending);
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(input kind_type k, input logic [31:0] pos,
                                        input logic [31:0] tgt, input logic dir,
                                        input logic sw);
      req_type r;
      r.kind               = k;
      r.position_value     = pos;
      r.target_value       = tgt;
      r.direction          = dir;
      r.home_switch_closed = sw;
      return r;
   endfunction

   function automatic req_type noise_req();
      return make_req(kind_type'($urandom_range(2)), $urandom(), $urandom(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   function automatic cfg_type make_cfg(input logic half, input logic [15:0] full_tbl,
                                        input logic [31:0] half_tbl, input logic home);
      cfg_type c;
      c.half_step_mode     = half;
      c.full_pattern_table = full_tbl;
      c.half_pattern_table = half_tbl;
      c.home_switch_enable = home;
      return c;
   endfunction

   // near zero, near either wrap point, or anywhere
   function automatic logic [31:0] pick_position();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return $urandom_range(24) - 32'd12;
         2:       return 32'h7FFF_FFFF - $urandom_range(6);
         default: return 32'h8000_0000 + $urandom_range(6);
      endcase
   endfunction

   task automatic send_item(input req_type item);
      if (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcomes_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      csr_write <= 1'b1;
      csr_index <= CSR_HALF_STEP_MODE;
      csr_wdata <= 32'(c.half_step_mode);
      @(posedge clock);
      csr_index <= CSR_FULL_PATTERN_TABLE;
      csr_wdata <= 32'(c.full_pattern_table);
      @(posedge clock);
      csr_index <= CSR_HALF_PATTERN_TABLE;
      csr_wdata <= c.half_pattern_table;
      @(posedge clock);
      csr_index <= CSR_HOME_SWITCH_ENABLE;
      csr_wdata <= 32'(c.home_switch_enable);
      @(posedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // mostly a load followed by a run of ticks, some stray items in between
   task automatic run_moves(input int budget);
      req_type     item;
      logic [31:0] start;
      int          span;
      int          ticks;
      int          closed_pct;
      int          left;
      bit          toward;
      left = budget;
      while (left > 0) begin
         if ($urandom_range(99) < 8) begin
            send_item(noise_req());
            left--;
         end else begin
            start = pick_position();
            span = $urandom_range(20);
            toward = ($urandom_range(3) != 0);
            item = noise_req();
            item.kind = KIND_LOAD;
            item.position_value = start;
            item.direction = 1'($urandom_range(1));
            if ($urandom_range(4) == 0)
               item.target_value = pick_position();
            else if (item.direction == toward)
               item.target_value = start - span;
            else
               item.target_value = start + span;
            send_item(item);
            left--;
            ticks = $urandom_range(24);
            closed_pct = 40 * $urandom_range(2);
            repeat (ticks) begin
               item = noise_req();
               item.kind = ($urandom_range(19) == 0) ? KIND_OFF : KIND_TICK;
               item.home_switch_closed = ($urandom_range(99) < closed_pct);
               send_item(item);
               left--;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_pct = 24;
      rsp_idle_pct <= 30;

      // reset settings: stopped ticks, immediate end, wrap, both homing outcomes
      send_item(make_req(KIND_TICK, 32'd5, -32'sd5, 1'b1, 1'b1));
      send_item(make_req(KIND_OFF, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_LOAD, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0, 1'b1));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b1));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b1));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b1));
      send_item(make_req(KIND_LOAD, 32'd3, -32'sd5, 1'b1, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b1));
      send_item(make_req(KIND_LOAD, 32'd2, -32'sd5, 1'b1, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
      send_item(make_req(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
      send_item(make_req(KIND_LOAD, -32'sd1, -32'sd3, 1'b1, 1'b1));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b1));
      send_item(make_req(KIND_OFF, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b0));
      send_item(make_req(KIND_TICK, 32'd0, 32'd0, 1'b0, 1'b0));
      drain_results();

      send_pct = 24;
      rsp_idle_pct <= 69;
      apply_config(make_cfg(1'b1, $urandom(), $urandom(), 1'b1));
      run_moves(180);
      drain_results();

      send_pct = 69;
      rsp_idle_pct <= 24;
      apply_config(make_cfg(1'b0, 16'hFFFF, 32'h0000_0000, 1'b0));
      run_moves(180);
      drain_results();

      send_pct = 0;
      rsp_idle_pct <= 0;
      apply_config(make_cfg(1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b1));
      run_moves(180);
      drain_results();

      // long result hold-off while items keep coming
      apply_config(make_cfg(1'b0, $urandom(), $urandom(), 1'b1));
      hold_toggle <= ~hold_toggle;
      run_moves(40);
      send_pct = 24;
      rsp_idle_pct <= 40;
      run_moves(170);
      drain_results();

      $display("tb_top: %0d items over %0d register settings, full and half step,",
               items_sent, settings_used);
      $display("tb_top: homing on and off, position wrap, idle patterns and a long hold-off");
      if (fail_count == 0 && outcomes_pending == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
